// ----- src/htw_pkg.sv -----
// ----------------------------------------------------------------------------
// htw_pkg - shared types for the hierarchical timing wheel
// Result kinds, front-to-back job format and the engine state encoding.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int LEVELS = 4;
  localparam int TOP_LEVEL = 3;

  typedef enum logic [1:0] {
    KIND_ADD_OK  = 2'd0,
    KIND_ADD_REJ = 2'd1,
    KIND_EXPIRY  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_REJECT,
    CMD_TICK
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [7:0]         tag;
    logic [31:0]        interval;
    logic signed [15:0] count;
  } job_t;

  typedef struct packed {
    kind_t      kind;
    logic [5:0] handle;
    logic [7:0] tag_out;
    logic       final_firing;
    logic       last;
  } res_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_ADD, S_ADD_OUT,
    S_FIRE0, S_FIRE1, S_FWALK, S_FEVT, S_FEND,
    S_ADV, S_MD0, S_MD1, S_MWALK, S_MNEXT,
    S_PL0, S_PL1, S_PL2,
    S_RARM0, S_RARM1, S_RARM2,
    S_DONE
  } eng_state_t;

  typedef enum logic [1:0] {
    RET_ADD,
    RET_MD,
    RET_RARM
  } ret_t;

endpackage

// ----- src/htw_in_if.sv -----
// ----------------------------------------------------------------------------
// htw_in_if - input channel of the timing wheel
// Valid/ready channel carrying one add or tick request per beat.
// ----------------------------------------------------------------------------
interface htw_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [7:0]         timer_tag;
  logic [31:0]        interval;
  logic signed [15:0] repeat_count;

  modport source (output valid, op, timer_tag, interval, repeat_count, input ready);
  modport sink   (input valid, op, timer_tag, interval, repeat_count, output ready);
endinterface

// ----- src/htw_out_if.sv -----
// ----------------------------------------------------------------------------
// htw_out_if - result channel of the timing wheel
// Valid/ready channel carrying one add response or expiry event per beat.
// ----------------------------------------------------------------------------
interface htw_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [5:0] handle;
  logic [7:0] tag_out;
  logic       final_firing;
  logic       last;

  modport source (output valid, kind, handle, tag_out, final_firing, last, input ready);
  modport sink   (input valid, kind, handle, tag_out, final_firing, last, output ready);
endinterface

// ----- src/htw_front.sv -----
// ----------------------------------------------------------------------------
// htw_front - request intake
// Classify each request beat and hold it in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module htw_front (
  input  logic          clk,
  input  logic          rst_n,
  htw_in_if.sink        in_ch,
  output htw_pkg::job_t job,
  output logic          job_valid,
  input  logic          job_pop
);
  import htw_pkg::*;

  job_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  job_t       cls;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign job_valid   = (cnt_r != 2'd0);
  assign job         = q_r[rp_r];

  // classify: tick, bad add (zero interval) or add with normalized count
  always_comb begin
    cls.tag      = in_ch.timer_tag;
    cls.interval = in_ch.interval;
    cls.count    = (in_ch.repeat_count == 16'sd0) ? 16'sd1 : in_ch.repeat_count;
    if (in_ch.op) begin
      cls.cmd = CMD_TICK;
    end else if (in_ch.interval == 32'd0) begin
      cls.cmd = CMD_REJECT;
    end else begin
      cls.cmd = CMD_ADD;
    end
  end

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ job_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, job_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end
endmodule

// ----- src/htw_back.sv -----
// ----------------------------------------------------------------------------
// htw_back - timing wheel engine
// Sequencer over the bucket tables and slot memories: add, fire, cascade,
// re-arm, with a one-event hold stage so the last flag can be set.
// ----------------------------------------------------------------------------
module htw_back #(
  parameter int NEAR_BITS  = 8,
  parameter int LEVEL_BITS = 6,
  parameter int MAX_TIMERS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  htw_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_pop,
  htw_out_if.source     out_ch
);
  import htw_pkg::*;

  localparam int SW  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int LW  = SW + 1;
  localparam int AW  = (NEAR_BITS > LEVEL_BITS + 2) ? NEAR_BITS : LEVEL_BITS + 2;
  localparam int IW  = AW + 1;
  localparam int TD  = 2 ** IW;
  localparam int RCW = $clog2(MAX_TIMERS + 1);
  localparam logic [LW-1:0] NIL = {1'b1, {SW{1'b0}}};

  // bucket tables: near buckets in the lower half, levels in the upper half
  logic [LW-1:0]      head_mem [TD];
  logic [SW-1:0]      tail_mem [TD];
  logic [LW-1:0]      next_mem [MAX_TIMERS];
  logic [7:0]         tag_mem  [MAX_TIMERS];
  logic [31:0]        int_mem  [MAX_TIMERS];
  logic signed [15:0] rem_mem  [MAX_TIMERS];
  logic [31:0]        exp_mem  [MAX_TIMERS];
  logic [SW-1:0]      rearm_mem [MAX_TIMERS];

  logic [LW-1:0]      head_rd, next_rd;
  logic [SW-1:0]      tail_rd, rearm_rd;
  logic [7:0]         tag_rd;
  logic [31:0]        int_rd, exp_rd;
  logic signed [15:0] rem_rd;

  eng_state_t state_r, state_nxt;
  ret_t       ret_r, ret_nxt;
  job_t       job_r, job_nxt;
  logic [31:0] now_r, now_nxt;
  logic [LW-1:0] cur_r, cur_nxt, nx_r, nx_nxt;
  logic [SW-1:0] pl_slot_r, pl_slot_nxt, k_r, k_nxt;
  logic [31:0] pl_exp_r, pl_exp_nxt;
  logic [IW-1:0] plb_r, plb_nxt, mdb_r, mdb_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  logic phase_r, phase_nxt;
  logic [RCW-1:0] rn_r, rn_nxt, ri_r, ri_nxt;
  logic [MAX_TIMERS-1:0] in_use_r, in_use_nxt;
  logic pend_v_r, pend_v_nxt, out_v_r, out_v_nxt;
  res_t pend_r, pend_nxt, out_r, out_d;
  logic load_out, out_can;

  // memory access controls
  logic [IW-1:0] ha, pb, nidx, head_wa;
  logic [LW-1:0] head_wd;
  logic [SW-1:0] sa, fs;
  logic free_any;
  logic head_we, tail_we, add_we, rem_we, exp_we, rearm_we, nxt_we;
  logic [SW-1:0] rem_wa, exp_wa, nxt_wa;
  logic signed [15:0] rem_wd;
  logic [31:0] exp_wd, ct;
  logic [LW-1:0] nxt_wd;
  logic fin;
  logic md_en;
  logic [1:0] md_lvl;
  logic [LEVEL_BITS-1:0] md_id;

  assign out_can = !out_v_r || out_ch.ready;
  assign nidx    = IW'(now_r[NEAR_BITS-1:0]);
  assign ha      = (state_r == S_MD0) ? mdb_r : ((state_r == S_PL0) ? pb : nidx);
  assign sa      = (state_r == S_RARM1) ? rearm_rd : cur_r[SW-1:0];
  assign ct      = now_r + 32'd1;

  // lowest free slot
  always_comb begin
    fs = '0;
    free_any = 1'b0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        fs = SW'(i);
        free_any = 1'b1;
      end
    end
  end

  // bucket of the timer being placed
  always_comb begin
    logic [31:0] d;
    logic [1:0]  lv;
    logic        found;
    logic [LEVEL_BITS-1:0] pid;
    d = pl_exp_r ^ now_r;
    lv = 2'(TOP_LEVEL);
    found = 1'b0;
    for (int i = 0; i < TOP_LEVEL; i++) begin
      if (!found && ((d >> (NEAR_BITS + (i + 1) * LEVEL_BITS)) == 32'd0)) begin
        lv = 2'(i);
        found = 1'b1;
      end
    end
    pid = LEVEL_BITS'(pl_exp_r >> (NEAR_BITS + int'(lv) * LEVEL_BITS));
    if ((d >> NEAR_BITS) == 32'd0) begin
      pb = IW'(pl_exp_r[NEAR_BITS-1:0]);
    end else begin
      pb = IW'(TD / 2) | IW'({lv, pid});
    end
  end

  // cascade selection for the advanced time
  always_comb begin
    logic stop;
    logic [LEVEL_BITS-1:0] id;
    stop = 1'b0;
    id = '0;
    md_en = 1'b0;
    md_lvl = 2'(TOP_LEVEL);
    md_id = '0;
    if (ct == 32'd0) begin
      md_en = 1'b1;
    end else begin
      for (int i = 0; i < LEVELS; i++) begin
        if (!stop) begin
          if ((ct & ((32'd1 << (NEAR_BITS + i * LEVEL_BITS)) - 32'd1)) != 32'd0) begin
            stop = 1'b1;
          end else begin
            id = LEVEL_BITS'(ct >> (NEAR_BITS + i * LEVEL_BITS));
            if (id != '0) begin
              md_en = 1'b1;
              md_lvl = 2'(i);
              md_id = id;
              stop = 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;   ret_nxt = ret_r;     job_nxt = job_r;
    now_nxt = now_r;       cur_nxt = cur_r;     nx_nxt = nx_r;
    pl_slot_nxt = pl_slot_r; pl_exp_nxt = pl_exp_r; k_nxt = k_r;
    plb_nxt = plb_r;       mdb_nxt = mdb_r;     phase_nxt = phase_r;
    rn_nxt = rn_r;         ri_nxt = ri_r;       in_use_nxt = in_use_r;
    clr_nxt = clr_r;       pend_v_nxt = pend_v_r; pend_nxt = pend_r;
    job_pop = 1'b0;        load_out = 1'b0;     out_d = '0;
    head_we = 1'b0; tail_we = 1'b0; add_we = 1'b0; rem_we = 1'b0;
    exp_we = 1'b0;  rearm_we = 1'b0; nxt_we = 1'b0;
    head_wa = plb_r; head_wd = {1'b0, pl_slot_r};
    rem_wa = fs; rem_wd = job_r.count;
    exp_wa = fs; exp_wd = now_r + job_r.interval;
    nxt_wa = pl_slot_r; nxt_wd = NIL;
    fin = (rem_rd == 16'sd1);
    unique case (state_r)
      // mark every bucket empty after reset
      S_CLR: begin
        head_we = 1'b1;
        head_wa = clr_r;
        head_wd = NIL;
        clr_nxt = clr_r + IW'(1);
        if (clr_r == IW'(TD - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          job_nxt = job;
          phase_nxt = 1'b0;
          rn_nxt = '0;
          state_nxt = (job.cmd == CMD_TICK) ? S_FIRE0 : S_ADD;
        end
      end
      S_ADD: begin
        if (job_r.cmd == CMD_REJECT || !free_any) begin
          if (out_can) begin
            load_out = 1'b1;
            out_d.kind = KIND_ADD_REJ;
            out_d.last = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          add_we = 1'b1;
          rem_we = 1'b1;
          exp_we = 1'b1;
          in_use_nxt[fs] = 1'b1;
          pl_slot_nxt = fs;
          pl_exp_nxt = now_r + job_r.interval;
          ret_nxt = RET_ADD;
          state_nxt = S_PL0;
        end
      end
      S_ADD_OUT: begin
        if (out_can) begin
          load_out = 1'b1;
          out_d.kind = KIND_ADD_OK;
          out_d.handle = 6'(pl_slot_r);
          out_d.last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FIRE0: state_nxt = S_FIRE1;
      S_FIRE1: begin
        if (head_rd[SW]) begin
          state_nxt = S_FEND;
        end else begin
          head_we = 1'b1;
          head_wa = nidx;
          head_wd = NIL;
          cur_nxt = head_rd;
          state_nxt = S_FWALK;
        end
      end
      S_FWALK: state_nxt = S_FEVT;
      S_FEVT: begin
        if (!pend_v_r || out_can) begin
          rem_wa = cur_r[SW-1:0];
          rem_wd = rem_rd - 16'sd1;
          rem_we = (rem_rd > 16'sd0);
          if (fin) begin
            in_use_nxt[cur_r[SW-1:0]] = 1'b0;
          end else begin
            rearm_we = 1'b1;
            rn_nxt = rn_r + RCW'(1);
          end
          if (pend_v_r) begin
            load_out = 1'b1;
            out_d = pend_r;
          end
          pend_v_nxt = 1'b1;
          pend_nxt.kind = KIND_EXPIRY;
          pend_nxt.handle = 6'(cur_r[SW-1:0]);
          pend_nxt.tag_out = tag_rd;
          pend_nxt.final_firing = fin;
          pend_nxt.last = 1'b0;
          if (next_rd[SW]) begin
            state_nxt = S_FEND;
          end else begin
            cur_nxt = next_rd;
            state_nxt = S_FWALK;
          end
        end
      end
      S_FEND: begin
        if (!phase_r) begin
          state_nxt = S_ADV;
        end else if (rn_r != '0) begin
          ri_nxt = '0;
          state_nxt = S_RARM0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ADV: begin
        now_nxt = ct;
        phase_nxt = 1'b1;
        mdb_nxt = IW'(TD / 2) | IW'({md_lvl, md_id});
        state_nxt = md_en ? S_MD0 : S_FIRE0;
      end
      S_MD0: state_nxt = S_MD1;
      S_MD1: begin
        if (head_rd[SW]) begin
          state_nxt = S_FIRE0;
        end else begin
          head_we = 1'b1;
          head_wa = mdb_r;
          head_wd = NIL;
          cur_nxt = head_rd;
          state_nxt = S_MWALK;
        end
      end
      S_MWALK: state_nxt = S_MNEXT;
      S_MNEXT: begin
        nx_nxt = next_rd;
        pl_slot_nxt = cur_r[SW-1:0];
        pl_exp_nxt = exp_rd;
        ret_nxt = RET_MD;
        state_nxt = S_PL0;
      end
      S_PL0: begin
        plb_nxt = pb;
        state_nxt = S_PL1;
      end
      S_PL1: begin
        if (!head_rd[SW]) begin
          nxt_we = 1'b1;
          nxt_wa = tail_rd;
          nxt_wd = {1'b0, pl_slot_r};
        end else begin
          head_we = 1'b1;
        end
        state_nxt = S_PL2;
      end
      S_PL2: begin
        nxt_we = 1'b1;
        tail_we = 1'b1;
        unique case (ret_r)
          RET_ADD: state_nxt = S_ADD_OUT;
          RET_MD: begin
            if (nx_r[SW]) begin
              state_nxt = S_FIRE0;
            end else begin
              cur_nxt = nx_r;
              state_nxt = S_MWALK;
            end
          end
          RET_RARM: begin
            ri_nxt = ri_r + RCW'(1);
            state_nxt = (ri_r + RCW'(1) == rn_r) ? S_DONE : S_RARM0;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_RARM0: state_nxt = S_RARM1;
      S_RARM1: begin
        k_nxt = rearm_rd;
        state_nxt = S_RARM2;
      end
      S_RARM2: begin
        exp_we = 1'b1;
        exp_wa = k_r;
        exp_wd = now_r + int_rd;
        pl_slot_nxt = k_r;
        pl_exp_nxt = now_r + int_rd;
        ret_nxt = RET_RARM;
        state_nxt = S_PL0;
      end
      S_DONE: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_can) begin
          load_out = 1'b1;
          out_d = pend_r;
          out_d.last = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (load_out) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      now_r    <= '0;
      in_use_r <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      phase_r  <= 1'b0;
      rn_r     <= '0;
      ri_r     <= '0;
      ret_r    <= RET_ADD;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      now_r    <= now_nxt;
      in_use_r <= in_use_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      phase_r  <= phase_nxt;
      rn_r     <= rn_nxt;
      ri_r     <= ri_nxt;
      ret_r    <= ret_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    cur_r     <= cur_nxt;
    nx_r      <= nx_nxt;
    pl_slot_r <= pl_slot_nxt;
    pl_exp_r  <= pl_exp_nxt;
    plb_r     <= plb_nxt;
    mdb_r     <= mdb_nxt;
    k_r       <= k_nxt;
    pend_r    <= pend_nxt;
    if (load_out) begin
      out_r <= out_d;
    end
  end

  // bucket tables
  always_ff @(posedge clk) begin
    head_rd <= head_mem[ha];
    tail_rd <= tail_mem[pb];
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (tail_we) begin
      tail_mem[plb_r] <= pl_slot_r;
    end
  end

  // slot memories
  always_ff @(posedge clk) begin
    next_rd  <= next_mem[sa];
    tag_rd   <= tag_mem[sa];
    int_rd   <= int_mem[sa];
    rem_rd   <= rem_mem[sa];
    exp_rd   <= exp_mem[sa];
    rearm_rd <= rearm_mem[ri_r[SW-1:0]];
    if (nxt_we) begin
      next_mem[nxt_wa] <= nxt_wd;
    end
    if (add_we) begin
      tag_mem[fs] <= job_r.tag;
      int_mem[fs] <= job_r.interval;
    end
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    if (exp_we) begin
      exp_mem[exp_wa] <= exp_wd;
    end
    if (rearm_we) begin
      rearm_mem[rn_r[SW-1:0]] <= cur_r[SW-1:0];
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.kind         = out_r.kind;
  assign out_ch.handle       = out_r.handle;
  assign out_ch.tag_out      = out_r.tag_out;
  assign out_ch.final_firing = out_r.final_firing;
  assign out_ch.last         = out_r.last;
endmodule

// ----- src/hierarchical_timing_wheel.sv -----
// ----------------------------------------------------------------------------
// hierarchical_timing_wheel - timer wheel with a near wheel and four levels
// Top level: request queue in front of the wheel engine.
// ----------------------------------------------------------------------------
// Each request beat is either an add (tag, interval, repeat count) or one
// tick. After reset the engine walks every bucket-table entry, marking
// every bucket empty before it takes the first request. An add answers
// with one beat, accepted with its slot handle or rejected. A tick fires
// the current near bucket, advances time, cascades at most one coarser
// bucket down, fires the new near bucket and re-arms repeating timers; it
// answers with one expiry beat per firing, the last one flagged, or with
// nothing. A two-entry queue takes new requests while the engine works
// and an output register holds each beat.
module hierarchical_timing_wheel #(
  parameter int NEAR_BITS  = 8,
  parameter int LEVEL_BITS = 6,
  parameter int MAX_TIMERS = 64
) (
  input logic       clk,
  input logic       rst_n,
  htw_in_if.sink    in_ch,
  htw_out_if.source out_ch
);
  import htw_pkg::*;

  job_t job;
  logic job_valid, job_pop;

  // intake: classify and queue request beats
  htw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop)
  );

  // engine: walk buckets, cascade, re-arm, drive result beats
  htw_back #(
    .NEAR_BITS  (NEAR_BITS),
    .LEVEL_BITS (LEVEL_BITS),
    .MAX_TIMERS (MAX_TIMERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .out_ch    (out_ch)
  );

  // add responses are single beats
  a_add_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind != KIND_EXPIRY |-> out_ch.last)
    else $error("add response without last");

  // only an expiry can free a slot
  a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.final_firing |-> out_ch.kind == KIND_EXPIRY)
    else $error("final flag on a non-expiry beat");

  // add responses carry no tag
  a_add_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind != KIND_EXPIRY |-> out_ch.tag_out == 8'd0)
    else $error("tag on an add response");
endmodule

// ----- verif/hierarchical_timing_wheel_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hierarchical_timing_wheel_tb - self-checking bench for the timing wheel
// Drives add and tick beats through the valid/ready request channel. A
// behavioral copy of the wheel (near wheel, four levels, slot table)
// predicts every add response and expiry event. Each result beat is checked
// field by field in arrival order. A short directed table comes first, then
// randomized traffic under three back-pressure phases.
// ----------------------------------------------------------------------------
module hierarchical_timing_wheel_tb;
  import htw_pkg::*;

  localparam int          WATCHDOG_LIMIT = 40000;
  localparam int          DRAIN_CYCLES   = 400;
  localparam int          RANDOM_ITEMS   = 460;
  localparam logic [6:0]  NIL            = 7'd127;
  localparam logic        OP_ADD         = 1'b0;
  localparam logic        OP_TICK        = 1'b1;

  // How a directed row is judged: by the wheel model only, by "no beat at
  // all", or by one beat typed into the table.
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} chk_t;

  typedef struct {
    logic               op;
    logic [7:0]         tag;
    logic [31:0]        interval;
    logic signed [15:0] count;
    chk_t               chk;
    res_t               want;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  htw_in_if  in_ch();
  htw_out_if out_ch();

  hierarchical_timing_wheel dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Wheel model: time, bucket lists and slot table
  // --------------------------------------------------------------------------
  logic [31:0]        now_tick;
  logic [6:0]         near_head [256];
  logic [6:0]         near_tail [256];
  logic [6:0]         lvl_head  [256];
  logic [6:0]         lvl_tail  [256];
  logic [6:0]         link_nx   [64];
  logic [7:0]         tmr_tag   [64];
  logic [31:0]        tmr_ivl   [64];
  int                 tmr_left  [64];
  logic [31:0]        tmr_due   [64];
  bit                 tmr_busy  [64];

  res_t               pending_q[$];   // beats still owed by the wheel
  int                 err_cnt = 0;
  int                 snd_idle = 13;
  int                 rcv_idle = 57;

  function automatic void wheel_clear();
    now_tick = '0;
    for (int i = 0; i < 256; i++) begin
      near_head[i] = NIL; near_tail[i] = '0;
      lvl_head[i] = NIL;  lvl_tail[i] = '0;
    end
    for (int i = 0; i < 64; i++) tmr_busy[i] = 1'b0;
  endfunction

  // Append slot s to the tail of a bucket list.
  function automatic void hang(bit on_near, int b, int s);
    link_nx[s] = NIL;
    if (on_near) begin
      if (near_head[b] == NIL) near_head[b] = s[6:0];
      else link_nx[near_tail[b][5:0]] = s[6:0];
      near_tail[b] = s[6:0];
    end else begin
      if (lvl_head[b] == NIL) lvl_head[b] = s[6:0];
      else link_nx[lvl_tail[b][5:0]] = s[6:0];
      lvl_tail[b] = s[6:0];
    end
  endfunction

  // File a slot in the near wheel when only the low byte differs from now,
  // else in the lowest level whose span covers the difference.
  function automatic void file_slot(int s);
    logic [63:0] e, c, m;
    int          lv;
    e = {32'd0, tmr_due[s]};
    c = {32'd0, now_tick};
    if ((e | 64'hff) == (c | 64'hff)) begin
      hang(1'b1, int'(e[7:0]), s);
    end else begin
      m = 64'd1 << 14;
      lv = 0;
      while (lv < TOP_LEVEL && (e | (m - 1)) != (c | (m - 1))) begin
        m = m << 6;
        lv++;
      end
      hang(1'b0, lv * 64 + int'((e >> (8 + lv * 6)) & 64'h3f), s);
    end
  endfunction

  function automatic void cascade(int lv, int idx);
    int b, s, nx;
    b = lv * 64 + (idx & 63);
    s = lvl_head[b];
    lvl_head[b] = NIL;
    while (s != NIL) begin
      nx = link_nx[s & 63];
      file_slot(s & 63);
      s = nx;
    end
  endfunction

  function automatic void step_time();
    logic [31:0] t;
    logic [63:0] m;
    int          lv;
    now_tick = now_tick + 1;
    if (now_tick == 0) begin
      cascade(TOP_LEVEL, 0);
    end else begin
      t = now_tick >> 8;
      m = 64'd1 << 8;
      lv = 0;
      while (lv < LEVELS && ({32'd0, now_tick} & (m - 1)) == 0) begin
        if ((t & 32'h3f) != 0) begin
          cascade(lv, int'(t & 32'h3f));
          break;
        end
        m = m << 6;
        t = t >> 6;
        lv++;
      end
    end
  endfunction

  // Fire the near bucket of the current time, oldest entry first.
  function automatic void fire_bucket(ref res_t evts[$], ref int rearm[$]);
    int   b, s, k, nx;
    bit   fin;
    res_t r;
    b = now_tick[7:0];
    s = near_head[b];
    near_head[b] = NIL;
    while (s != NIL) begin
      k = s & 63;
      nx = link_nx[k];
      fin = 1'b0;
      if (tmr_left[k] > 0) begin
        tmr_left[k]--;
        if (tmr_left[k] <= 0) fin = 1'b1;
      end
      if (fin) tmr_busy[k] = 1'b0;
      else if (rearm.size() < 64) rearm.push_back(k);
      if (evts.size() < 64) begin
        r.kind = KIND_EXPIRY;
        r.handle = k[5:0];
        r.tag_out = tmr_tag[k];
        r.final_firing = fin;
        r.last = 1'b0;
        evts.push_back(r);
      end
      s = nx;
    end
  endfunction

  // Work out the beats that one accepted request causes.
  function automatic void wheel_apply(input stim_t it, ref res_t evts[$]);
    int   s, cnt;
    int   rearm[$];
    res_t r;
    evts.delete();
    if (it.op == OP_ADD) begin
      cnt = (it.count == 0) ? 1 : int'(it.count);
      s = 0;
      while (s < 64 && tmr_busy[s]) s++;
      r = '{kind: KIND_ADD_REJ, handle: '0, tag_out: '0, final_firing: 1'b0, last: 1'b1};
      if (it.interval != 0 && s < 64) begin
        tmr_busy[s] = 1'b1;
        tmr_tag[s] = it.tag;
        tmr_ivl[s] = it.interval;
        tmr_left[s] = cnt;
        tmr_due[s] = now_tick + it.interval;
        file_slot(s);
        r.kind = KIND_ADD_OK;
        r.handle = s[5:0];
      end
      evts.push_back(r);
    end else begin
      fire_bucket(evts, rearm);
      step_time();
      fire_bucket(evts, rearm);
      foreach (rearm[i]) begin
        tmr_due[rearm[i]] = now_tick + tmr_ivl[rearm[i]];
        file_slot(rearm[i]);
      end
      if (evts.size() > 0) evts[evts.size() - 1].last = 1'b1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: drive at the falling edge, detect the beat at the rising
  // edge, then let the model commit the request.
  // --------------------------------------------------------------------------
  task automatic send_req(input stim_t it);
    res_t evts[$];
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= it.op;
    in_ch.timer_tag    <= it.tag;
    in_ch.interval     <= it.interval;
    in_ch.repeat_count <= it.count;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    wheel_apply(it, evts);
    // Cross-check rows whose answer is plain from the table itself.
    if ((it.chk == CHK_NONE && evts.size() != 0) ||
        (it.chk == CHK_ONE && (evts.size() != 1 || evts[0] != it.want))) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("directed row: model gives %0d beats, first %p, table %p",
                 evts.size(), evts.size() ? evts[0] : '0, it.want);
    end
    foreach (evts[i]) pending_q.push_back(evts[i]);
    @(negedge clk);
  endtask

  function automatic stim_t row(logic op, logic [7:0] tag, logic [31:0] ivl,
                                logic signed [15:0] cnt, chk_t chk, res_t want);
    stim_t it;
    it.op = op; it.tag = tag; it.interval = ivl; it.count = cnt;
    it.chk = chk; it.want = want;
    return it;
  endfunction

  function automatic stim_t random_req();
    stim_t it;
    int    p;
    it.chk = CHK_MODEL;
    it.want = '0;
    it.op = ($urandom_range(99) < 50) ? OP_TICK : OP_ADD;
    it.tag = 8'($urandom_range(255));
    p = $urandom_range(99);
    // Mostly short intervals so timers fire and cascade within the run.
    if (p < 3)       it.interval = '0;
    else if (p < 8)  it.interval = $urandom;
    else if (p < 20) it.interval = $urandom_range(20000, 256);
    else             it.interval = $urandom_range(300, 1);
    p = $urandom_range(99);
    if (p < 8)       it.count = -$signed(16'($urandom_range(32768, 1)));
    else if (p < 13) it.count = 16'($urandom);
    else             it.count = 16'($urandom_range(3));
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random ready, compare each beat with the oldest expectation.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    res_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected beat kind=%0d handle=%0d tag=%0h", out_ch.kind,
                   out_ch.handle, out_ch.tag_out);
      end else begin
        w = pending_q.pop_front();
        if (out_ch.kind !== w.kind || out_ch.handle !== w.handle ||
            out_ch.tag_out !== w.tag_out || out_ch.final_firing !== w.final_firing ||
            out_ch.last !== w.last) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("beat mismatch: want k=%0d h=%0d t=%0h f=%0b l=%0b, got k=%0d h=%0d t=%0h f=%0b l=%0b",
                     w.kind, w.handle, w.tag_out, w.final_firing, w.last, out_ch.kind,
                     out_ch.handle, out_ch.tag_out, out_ch.final_firing, out_ch.last);
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on either channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else if (rst_n)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("hierarchical_timing_wheel_tb: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  stim_t dir_tab[$];

  initial begin
    res_t none;
    none = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_ADD;
    in_ch.timer_tag = '0;
    in_ch.interval = '0;
    in_ch.repeat_count = '0;
    out_ch.ready = 1'b0;
    wheel_clear();

    // Empty tick, zero-interval reject, one-shot timer firing on next tick,
    // wrap-around and huge intervals, forever and max counts, level spans.
    dir_tab.push_back(row(OP_TICK, 8'h00, 32'd0, 16'sd0, CHK_NONE, none));
    dir_tab.push_back(row(OP_ADD, 8'h00, 32'd0, 16'sd5, CHK_ONE,
                          '{KIND_ADD_REJ, 6'd0, 8'h00, 1'b0, 1'b1}));
    dir_tab.push_back(row(OP_ADD, 8'hff, 32'd1, 16'sd0, CHK_ONE,
                          '{KIND_ADD_OK, 6'd0, 8'h00, 1'b0, 1'b1}));
    dir_tab.push_back(row(OP_TICK, 8'h00, 32'd0, 16'sd0, CHK_ONE,
                          '{KIND_EXPIRY, 6'd0, 8'hff, 1'b1, 1'b1}));
    dir_tab.push_back(row(OP_ADD, 8'h00, 32'hffff_ffff, -16'sd1, CHK_ONE,
                          '{KIND_ADD_OK, 6'd0, 8'h00, 1'b0, 1'b1}));
    dir_tab.push_back(row(OP_ADD, 8'h5a, 32'h8000_0000, -16'sd32768, CHK_ONE,
                          '{KIND_ADD_OK, 6'd1, 8'h00, 1'b0, 1'b1}));
    dir_tab.push_back(row(OP_ADD, 8'ha5, 32'd255, 16'sd32767, CHK_MODEL, none));
    dir_tab.push_back(row(OP_ADD, 8'h03, 32'd1, 16'sd2, CHK_MODEL, none));
    dir_tab.push_back(row(OP_ADD, 8'h11, 32'h0000_4000, 16'sd1, CHK_MODEL, none));
    dir_tab.push_back(row(OP_ADD, 8'h22, 32'd2, -16'sd5, CHK_MODEL, none));
    dir_tab.push_back(row(OP_ADD, 8'h33, 32'h0000_ffff, 16'sd0, CHK_MODEL, none));
    dir_tab.push_back(row(OP_ADD, 8'h44, 32'h0010_0000, 16'sd3, CHK_MODEL, none));
    for (int i = 0; i < 8; i++)
      dir_tab.push_back(row(OP_TICK, 8'h00, 32'd0, 16'sd0, CHK_MODEL, none));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) send_req(dir_tab[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Swap the idle ratios, then run with neither side idling.
      if (n == RANDOM_ITEMS / 3) begin
        snd_idle = 57; rcv_idle = 13;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        snd_idle = 0; rcv_idle = 0;
      end
      // Hold requests once until the wheel has answered everything.
      if (n == RANDOM_ITEMS / 2) begin
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
      end
      send_req(random_req());
    end
    in_ch.valid <= 1'b0;

    while (pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0)
      $display("hierarchical_timing_wheel_tb: done, clean");
    else
      $display("hierarchical_timing_wheel_tb: done, errors");
    $finish;
  end

endmodule

// ----- hierarchical_timing_wheel.f -----
src/htw_pkg.sv
src/htw_in_if.sv
src/htw_out_if.sv
src/htw_front.sv
src/htw_back.sv
src/hierarchical_timing_wheel.sv
verif/hierarchical_timing_wheel_tb.sv
